/* sv/ccirc_pkg.sv */
package ccirc_pkg;

	// coordinate and intermediate widths
	localparam int CW   = 32;          // coordinate
	localparam int DFW  = CW + 1;      // coordinate difference
	localparam int PW   = 2 * DFW;     // product of two differences
	localparam int HW   = DFW;         // half of a squared-length word
	localparam int PPW  = HW + 1 + DFW; // partial product of a half with a difference
	localparam int DW   = PW + 2;      // doubled cross product
	localparam int NW   = 100;         // centre numerator
	localparam int QW   = 42;          // quotient bits kept
	localparam int QLIM_EXP = 40;      // quotient above 2**QLIM_EXP saturates
	localparam int RW   = DFW;         // radius root bits
	localparam int SUMW = QW + 2;      // base plus quotient

	// register indexes
	localparam logic REG_NEAR_TOL  = 1'b0;
	localparam logic REG_COLIN_TOL = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_CLOSED = 2'd1;
	localparam logic [1:0] ST_COLIN  = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic               closed;
		logic               colin;
		logic signed [CW-1:0] mx;
		logic signed [CW-1:0] my;
		logic signed [CW-1:0] x1;
		logic signed [CW-1:0] y1;
	} front_side_t;

	typedef struct packed {
		logic        neg;
		front_side_t f;
	} div_side_t;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic                 sat;
		logic                 closed;
		logic                 colin;
	} post_side_t;

endpackage

/* sv/circumcircle_from_three_points.sv */
// circumcircle of three points, fully pipelined
// structure: 7 front stages, 43 stages per centre divider (an overflow check stage,
// then one quotient bit per stage), 4 centre/square stages, 34 root stages (an input
// register, then one root bit per stage), 1 output register
// throughput: one triple per cycle; a stalled output freezes the whole pipeline
// reset: arst_n clears all valid bits and both tolerance registers to 0
module circumcircle_from_three_points (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  logic        valid,
	output logic        ready,
	input  logic signed [31:0] x1,
	input  logic signed [31:0] y1,
	input  logic signed [31:0] x2,
	input  logic signed [31:0] y2,
	input  logic signed [31:0] x3,
	input  logic signed [31:0] y3,
	// result channel
	output logic        res_valid,
	input  logic        res_ready,
	output logic signed [31:0] center_x,
	output logic signed [31:0] center_y,
	output logic [31:0] radius,
	output logic [1:0]  status
);

	localparam int CW   = ccirc_pkg::CW;
	localparam int DFW  = ccirc_pkg::DFW;
	localparam int PW   = ccirc_pkg::PW;
	localparam int DW   = ccirc_pkg::DW;
	localparam int NW   = ccirc_pkg::NW;
	localparam int QW   = ccirc_pkg::QW;
	localparam int RW   = ccirc_pkg::RW;
	localparam int SUMW = ccirc_pkg::SUMW;
	localparam logic signed [SUMW-1:0] CMAX = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] CMIN = ~CMAX;
	localparam logic [QW-1:0] QLIM = QW'(1) << ccirc_pkg::QLIM_EXP;

	logic [15:0] near_tol_q;
	logic [31:0] colin_tol_q;
	logic en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_tol_q <= '0;
			colin_tol_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ccirc_pkg::REG_NEAR_TOL:  near_tol_q <= pwdata[15:0];
				ccirc_pkg::REG_COLIN_TOL: colin_tol_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ccirc_pkg::REG_NEAR_TOL:  prdata = {16'd0, near_tol_q};
			ccirc_pkg::REG_COLIN_TOL: prdata = colin_tol_q;
			default:                  prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// pipeline advances unless a result waits untaken
	assign en = !res_valid || res_ready;
	assign ready = en;

	// front: differences, products, numerators
	logic f_v;
	logic [NW-1:0] f_nx, f_ny;
	logic [DW-1:0] f_d;
	logic f_negx, f_negy;
	ccirc_pkg::front_side_t f_side;

	ccirc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.v_in      (valid),
		.x1        (x1),
		.y1        (y1),
		.x2        (x2),
		.y2        (y2),
		.x3        (x3),
		.y3        (y3),
		.near_tol  (near_tol_q),
		.colin_tol (colin_tol_q),
		.v_out     (f_v),
		.nx_abs    (f_nx),
		.ny_abs    (f_ny),
		.d_abs     (f_d),
		.negx      (f_negx),
		.negy      (f_negy),
		.side      (f_side)
	);

	// centre dividers
	ccirc_pkg::div_side_t dx_in, dx_out;
	logic dx_v, dy_v, dx_ovf, dy_ovf, dy_neg;
	logic [QW-1:0] dx_q, dy_q;

	assign dx_in.neg = f_negx;
	assign dx_in.f = f_side;

	ccirc_div #(.NW(NW), .DW(DW), .QW(QW), .SW($bits(ccirc_pkg::div_side_t))) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (f_v),
		.n        (f_nx),
		.d        (f_d),
		.side_in  (dx_in),
		.v_out    (dx_v),
		.q        (dx_q),
		.ovf      (dx_ovf),
		.side_out (dx_out)
	);

	ccirc_div #(.NW(NW), .DW(DW), .QW(QW), .SW(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (f_v),
		.n        (f_ny),
		.d        (f_d),
		.side_in  (f_negy),
		.v_out    (dy_v),
		.q        (dy_q),
		.ovf      (dy_ovf),
		.side_out (dy_neg)
	);

	// stage 1: offset, clamp, select closed or colinear case
	logic signed [SUMW-1:0] sx, sy;
	logic satx, saty;
	logic signed [CW-1:0] cxc, cyc;
	logic signed [CW-1:0] cx_s1, cy_s1, x1_s1, y1_s1;
	logic sat_s1, closed_s1, colin_s1;

	always_comb begin
		sx = dx_out.neg ? SUMW'(dx_out.f.x1) - SUMW'({1'b0, dx_q})
				: SUMW'(dx_out.f.x1) + SUMW'({1'b0, dx_q});
		sy = dy_neg ? SUMW'(dx_out.f.y1) - SUMW'({1'b0, dy_q})
				: SUMW'(dx_out.f.y1) + SUMW'({1'b0, dy_q});
		satx = 1'b1;
		if (dx_ovf || dx_q > QLIM) begin
			cxc = dx_out.neg ? CMIN[CW-1:0] : CMAX[CW-1:0];
		end else if (sx > CMAX) begin
			cxc = CMAX[CW-1:0];
		end else if (sx < CMIN) begin
			cxc = CMIN[CW-1:0];
		end else begin
			cxc = sx[CW-1:0];
			satx = 1'b0;
		end
		saty = 1'b1;
		if (dy_ovf || dy_q > QLIM) begin
			cyc = dy_neg ? CMIN[CW-1:0] : CMAX[CW-1:0];
		end else if (sy > CMAX) begin
			cyc = CMAX[CW-1:0];
		end else if (sy < CMIN) begin
			cyc = CMIN[CW-1:0];
		end else begin
			cyc = sy[CW-1:0];
			saty = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dx_out.f.closed) begin
				cx_s1 <= dx_out.f.mx;
				cy_s1 <= dx_out.f.my;
				sat_s1 <= 1'b0;
			end else if (dx_out.f.colin) begin
				cx_s1 <= '0;
				cy_s1 <= '0;
				sat_s1 <= 1'b0;
			end else begin
				cx_s1 <= cxc;
				cy_s1 <= cyc;
				sat_s1 <= satx || saty;
			end
			closed_s1 <= dx_out.f.closed;
			colin_s1 <= dx_out.f.colin && !dx_out.f.closed;
			x1_s1 <= dx_out.f.x1;
			y1_s1 <= dx_out.f.y1;
		end
	end

	// stage 2: offset from point one
	logic signed [DFW-1:0] ex_s2, ey_s2;
	ccirc_pkg::post_side_t ps_s2, ps_s3, ps_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s2 <= DFW'(cx_s1) - DFW'(x1_s1);
			ey_s2 <= DFW'(cy_s1) - DFW'(y1_s1);
			ps_s2.cx <= cx_s1;
			ps_s2.cy <= cy_s1;
			ps_s2.sat <= sat_s1;
			ps_s2.closed <= closed_s1;
			ps_s2.colin <= colin_s1;
		end
	end

	// stage 3: squares
	logic signed [PW-1:0] ex2_s3, ey2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ex2_s3 <= ex_s2 * ex_s2;
			ey2_s3 <= ey_s2 * ey_s2;
			ps_s3 <= ps_s2;
		end
	end

	// stage 4: squared distance
	logic [PW-1:0] sq_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4 <= $unsigned(ex2_s3) + $unsigned(ey2_s3);
			ps_s4 <= ps_s3;
		end
	end

	// valid bits of the centre stages
	logic [4:1] v_c;
	logic r_v_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c <= '0;
		end else if (en) begin
			v_c <= {v_c[3:1], dx_v && dy_v};
		end
	end

	assign r_v_in = v_c[4];

	// root
	logic r_v;
	logic [RW-1:0] r_root;
	ccirc_pkg::post_side_t r_side;

	ccirc_sqrt #(.RW(RW), .SW($bits(ccirc_pkg::post_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (r_v_in),
		.sq       (sq_s4),
		.side_in  (ps_s4),
		.v_out    (r_v),
		.root     (r_root),
		.side_out (r_side)
	);

	// output register
	logic rsat;

	assign rsat = (r_root[RW-1:CW] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= r_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			center_x <= r_side.cx;
			center_y <= r_side.cy;
			if (r_side.colin) begin
				radius <= '0;
				status <= ccirc_pkg::ST_COLIN;
			end else begin
				radius <= rsat ? '1 : r_root[CW-1:0];
				if (rsat || r_side.sat) begin
					status <= ccirc_pkg::ST_SAT;
				end else if (r_side.closed) begin
					status <= ccirc_pkg::ST_CLOSED;
				end else begin
					status <= ccirc_pkg::ST_OK;
				end
			end
		end
	end

endmodule

/* sv/ccirc_front.sv */
module ccirc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                v_in,
	input  logic signed [ccirc_pkg::CW-1:0]     x1,
	input  logic signed [ccirc_pkg::CW-1:0]     y1,
	input  logic signed [ccirc_pkg::CW-1:0]     x2,
	input  logic signed [ccirc_pkg::CW-1:0]     y2,
	input  logic signed [ccirc_pkg::CW-1:0]     x3,
	input  logic signed [ccirc_pkg::CW-1:0]     y3,
	input  logic [15:0]                         near_tol,
	input  logic [31:0]                         colin_tol,
	output logic                                v_out,
	output logic [ccirc_pkg::NW-1:0]            nx_abs,
	output logic [ccirc_pkg::NW-1:0]            ny_abs,
	output logic [ccirc_pkg::DW-1:0]            d_abs,
	output logic                                negx,
	output logic                                negy,
	output ccirc_pkg::front_side_t              side
);

	localparam int DFW = ccirc_pkg::DFW;
	localparam int PW  = ccirc_pkg::PW;
	localparam int HW  = ccirc_pkg::HW;
	localparam int PPW = ccirc_pkg::PPW;
	localparam int DW  = ccirc_pkg::DW;
	localparam int NW  = ccirc_pkg::NW;

	logic [7:1] v_s;

	// stage 1: differences, closed test, midpoint
	logic signed [DFW-1:0] d13x, d13y, smx, smy;
	logic [DFW-1:0] a13x, a13y;
	logic signed [DFW-1:0] dx21_s1, dy21_s1, dx31_s1, dy31_s1;
	ccirc_pkg::front_side_t sd_s1;

	always_comb begin
		d13x = DFW'(x1) - DFW'(x3);
		d13y = DFW'(y1) - DFW'(y3);
		a13x = d13x[DFW-1] ? DFW'(-d13x) : DFW'(d13x);
		a13y = d13y[DFW-1] ? DFW'(-d13y) : DFW'(d13y);
		smx = DFW'(x1) + DFW'(x2);
		smy = DFW'(y1) + DFW'(y2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx21_s1 <= DFW'(x2) - DFW'(x1);
			dy21_s1 <= DFW'(y2) - DFW'(y1);
			dx31_s1 <= DFW'(x3) - DFW'(x1);
			dy31_s1 <= DFW'(y3) - DFW'(y1);
			sd_s1.closed <= (a13x <= DFW'(near_tol)) && (a13y <= DFW'(near_tol));
			sd_s1.colin <= 1'b0;
			sd_s1.mx <= smx[DFW-1:1];
			sd_s1.my <= smy[DFW-1:1];
			sd_s1.x1 <= x1;
			sd_s1.y1 <= y1;
		end
	end

	// stage 2: cross and square products
	logic signed [PW-1:0] p1_s2, p2_s2, sxa_s2, sya_s2, sxb_s2, syb_s2;
	logic signed [DFW-1:0] dx21_s2, dy21_s2, dx31_s2, dy31_s2;
	ccirc_pkg::front_side_t sd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2 <= dx21_s1 * dy31_s1;
			p2_s2 <= dx31_s1 * dy21_s1;
			sxa_s2 <= dx21_s1 * dx21_s1;
			sya_s2 <= dy21_s1 * dy21_s1;
			sxb_s2 <= dx31_s1 * dx31_s1;
			syb_s2 <= dy31_s1 * dy31_s1;
			dx21_s2 <= dx21_s1;
			dy21_s2 <= dy21_s1;
			dx31_s2 <= dx31_s1;
			dy31_s2 <= dy31_s1;
			sd_s2 <= sd_s1;
		end
	end

	// stage 3: doubled cross product and squared lengths
	logic signed [DW-1:0] dd, d_s3;
	logic [PW-1:0] h21_s3, h31_s3;
	logic signed [DFW-1:0] dx21_s3, dy21_s3, dx31_s3, dy31_s3;
	ccirc_pkg::front_side_t sd_s3;

	assign dd = DW'(p1_s2) - DW'(p2_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= dd <<< 1;
			h21_s3 <= $unsigned(sxa_s2) + $unsigned(sya_s2);
			h31_s3 <= $unsigned(sxb_s2) + $unsigned(syb_s2);
			dx21_s3 <= dx21_s2;
			dy21_s3 <= dy21_s2;
			dx31_s3 <= dx31_s2;
			dy31_s3 <= dy31_s2;
			sd_s3 <= sd_s2;
		end
	end

	// stage 4: partial products of numerators, colinear test
	logic signed [HW:0] h21l, h21h, h31l, h31h;
	logic [DW-1:0] ad;
	logic signed [PPW-1:0] pal_s4, pah_s4, pbl_s4, pbh_s4;
	logic signed [PPW-1:0] pcl_s4, pch_s4, pdl_s4, pdh_s4;
	logic [DW-1:0] ad_s4;
	logic dneg_s4;
	ccirc_pkg::front_side_t sd_s4;

	always_comb begin
		h21l = $signed({1'b0, h21_s3[HW-1:0]});
		h21h = $signed({1'b0, h21_s3[PW-1:HW]});
		h31l = $signed({1'b0, h31_s3[HW-1:0]});
		h31h = $signed({1'b0, h31_s3[PW-1:HW]});
		ad = d_s3[DW-1] ? DW'(-d_s3) : DW'(d_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pal_s4 <= h21l * dy31_s3;
			pah_s4 <= h21h * dy31_s3;
			pbl_s4 <= h31l * dy21_s3;
			pbh_s4 <= h31h * dy21_s3;
			pcl_s4 <= h31l * dx21_s3;
			pch_s4 <= h31h * dx21_s3;
			pdl_s4 <= h21l * dx31_s3;
			pdh_s4 <= h21h * dx31_s3;
			ad_s4 <= ad;
			dneg_s4 <= d_s3[DW-1];
			sd_s4.closed <= sd_s3.closed;
			sd_s4.colin <= (ad <= DW'(colin_tol));
			sd_s4.mx <= sd_s3.mx;
			sd_s4.my <= sd_s3.my;
			sd_s4.x1 <= sd_s3.x1;
			sd_s4.y1 <= sd_s3.y1;
		end
	end

	// stage 5: assemble the four terms
	logic signed [NW-1:0] ta_s5, tb_s5, tc_s5, td_s5;
	logic [DW-1:0] ad_s5;
	logic dneg_s5;
	ccirc_pkg::front_side_t sd_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s5 <= (NW'(pah_s4) <<< HW) + NW'(pal_s4);
			tb_s5 <= (NW'(pbh_s4) <<< HW) + NW'(pbl_s4);
			tc_s5 <= (NW'(pch_s4) <<< HW) + NW'(pcl_s4);
			td_s5 <= (NW'(pdh_s4) <<< HW) + NW'(pdl_s4);
			ad_s5 <= ad_s4;
			dneg_s5 <= dneg_s4;
			sd_s5 <= sd_s4;
		end
	end

	// stage 6: numerators
	logic signed [NW-1:0] nx_s6, ny_s6;
	logic [DW-1:0] ad_s6;
	logic dneg_s6;
	ccirc_pkg::front_side_t sd_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s6 <= ta_s5 - tb_s5;
			ny_s6 <= tc_s5 - td_s5;
			ad_s6 <= ad_s5;
			dneg_s6 <= dneg_s5;
			sd_s6 <= sd_s5;
		end
	end

	// stage 7: magnitudes and quotient signs
	always_ff @(posedge clk) begin
		if (en) begin
			nx_abs <= nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
			ny_abs <= ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);
			negx <= nx_s6[NW-1] ^ dneg_s6;
			negy <= ny_s6[NW-1] ^ dneg_s6;
			d_abs <= ad_s6;
			side <= sd_s6;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[6:1], v_in};
		end
	end

	assign v_out = v_s[7];

endmodule

/* sv/ccirc_div.sv */
module ccirc_div #(
	parameter int NW = 100,
	parameter int DW = 68,
	parameter int QW = 42,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	input  logic [SW-1:0] side_in,
	output logic          v_out,
	output logic [QW-1:0] q,
	output logic          ovf,
	output logic [SW-1:0] side_out
);

	localparam int NH = NW - QW;
	localparam int XW = (NH > DW) ? NH : DW;

	logic [DW-1:0] r_s   [QW+1];
	logic [QW-1:0] nl_s  [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic [DW-1:0] d_s   [QW+1];
	logic          ovf_s [QW+1];
	logic [SW-1:0] sd_s  [QW+1];
	logic [QW:0]   v_s;

	// first stage: overflow check and initial partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= DW'(n[NW-1:QW]);
			nl_s[0] <= n[QW-1:0];
			q_s[0] <= '0;
			d_s[0] <= d;
			ovf_s[0] <= (XW'(n[NW-1:QW]) >= XW'(d));
			sd_s[0] <= side_in;
		end
	end

	// one quotient bit per stage
	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DW:0] rt, rn;
		logic ge;

		always_comb begin
			rt = {r_s[i-1], nl_s[i-1][QW-1]};
			ge = (rt >= {1'b0, d_s[i-1]});
			rn = ge ? rt - {1'b0, d_s[i-1]} : rt;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i] <= rn[DW-1:0];
				nl_s[i] <= nl_s[i-1] << 1;
				q_s[i] <= {q_s[i-1][QW-2:0], ge};
				d_s[i] <= d_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-1:0], v_in};
		end
	end

	assign v_out = v_s[QW];
	assign q = q_s[QW];
	assign ovf = ovf_s[QW];
	assign side_out = sd_s[QW];

endmodule

/* sv/ccirc_sqrt.sv */
module ccirc_sqrt #(
	parameter int RW = 33,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  logic [2*RW-1:0] sq,
	input  logic [SW-1:0]   side_in,
	output logic            v_out,
	output logic [RW-1:0]   root,
	output logic [SW-1:0]   side_out
);

	localparam int MW = RW + 2;
	localparam int TW = RW + 4;

	logic [MW-1:0]   rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [2*RW-1:0] sq_s   [RW+1];
	logic [SW-1:0]   sd_s   [RW+1];
	logic [RW:0]     v_s;

	// input register
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			root_s[0] <= '0;
			sq_s[0] <= sq;
			sd_s[0] <= side_in;
		end
	end

	// one root bit per stage, two radicand bits consumed
	for (genvar k = 1; k <= RW; k++) begin : g_step
		logic [TW-1:0] tmp, trial, nrem;
		logic ge;

		always_comb begin
			tmp = {rem_s[k-1], sq_s[k-1][2*RW-1 -: 2]};
			trial = TW'({root_s[k-1], 2'b01});
			ge = (tmp >= trial);
			nrem = ge ? tmp - trial : tmp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= nrem[MW-1:0];
				root_s[k] <= {root_s[k-1][RW-2:0], ge};
				sq_s[k] <= sq_s[k-1] << 2;
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[RW-1:0], v_in};
		end
	end

	assign v_out = v_s[RW];
	assign root = root_s[RW];
	assign side_out = sd_s[RW];

endmodule
